// ----- sv/stick_radial_deadzone_macros.svh -----
// Assertion macros shared by the stick radial deadzone RTL.
`ifndef STICK_RADIAL_DEADZONE_MACROS_SVH
`define STICK_RADIAL_DEADZONE_MACROS_SVH

// Check a property on every rising edge of clk_i outside reset.
`define SRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SRD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/srd_pkg.sv -----
// Package: widths, constants and sideband types of the stick radial deadzone.
package srd_pkg;

  localparam int AxisW     = 16;  // one stick axis
  localparam int CfgW      = 16;  // deadzone register, unsigned Q0.16
  localparam int SumW      = 32;  // x*x + y*y
  localparam int RootW     = 16;  // floor(sqrt(sum)), at most 46340
  localparam int DqW       = 31;  // deadzone edge, deadzone * 32767
  localparam int ProdW     = 47;  // magnitude * numerator core
  localparam int DenW      = 47;  // (32767*65536 - dq) * r
  localparam int NumW      = 62;  // magnitude * numerator core * 32767
  localparam int QW        = 16;  // quotient bits per axis
  localparam int SqrtSteps = 16;  // one root bit per stage
  localparam int DivSteps  = 16;  // one quotient bit per stage
  localparam int FullShift = 15;  // 32767 = 2^15 - 1

  localparam logic [CfgW-1:0]  DzMaxReg  = 16'd62259;
  localparam logic [DqW-1:0]   DzFullOne = 31'd2147418112;  // 32767 * 65536
  localparam logic [RootW-1:0] RootClamp = 16'd32767;
  localparam logic [RootW-1:0] RootMax   = 16'd46340;

  // Sideband that travels alongside the square root.
  typedef struct packed {
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
    logic [DqW-1:0]          dq;
    logic                    bypass;
  } srd_side_t;

  // Sideband that travels alongside the divider.
  typedef struct packed {
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
    logic                    bypass;
    logic                    in_zone;
  } srd_fin_t;

endpackage

// ----- sv/srd_if.sv -----
// Interfaces: sample, result and configuration channels of the stick radial deadzone.
interface srd_in_if;
  import srd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [AxisW-1:0] x_in;
  logic signed [AxisW-1:0] y_in;
  modport source (output valid, output x_in, output y_in, input ready);
  modport sink (input valid, input x_in, input y_in, output ready);
endinterface

interface srd_out_if;
  import srd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [AxisW-1:0] x_out;
  logic signed [AxisW-1:0] y_out;
  modport source (output valid, output x_out, output y_out, input ready);
  modport sink (input valid, input x_out, input y_out, output ready);
endinterface

interface srd_cfg_if;
  import srd_pkg::*;
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] deadzone;
  modport source (output valid, output deadzone, input ready);
  modport sink (input valid, input deadzone, output ready);
endinterface

// ----- sv/srd_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, with elastic stall.
module srd_isqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [srd_pkg::SumW-1:0] in_sum_i,
  input  srd_pkg::srd_side_t      in_side_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [srd_pkg::RootW-1:0] out_root_o,
  output srd_pkg::srd_side_t      out_side_o
);
  import srd_pkg::*;

  typedef struct packed {
    logic [SumW-1:0] n;
    logic [SumW-1:0] res;
  } sq_t;

  // One step of the bitwise square root, bit weight 4^(SqrtSteps-1-k).
  function automatic sq_t sqrt_step(sq_t s, int k);
    logic [SumW-1:0] bitv;
    logic [SumW-1:0] trial;
    sq_t             o;
    bitv  = SumW'(1) << (2 * (SqrtSteps - 1 - k));
    trial = s.res + bitv;
    if (s.n >= trial) begin
      o.n   = s.n - trial;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.n   = s.n;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  sq_t              st_q [SqrtSteps];
  sq_t              st_d [SqrtSteps];
  srd_side_t        side_q [SqrtSteps];
  logic [SqrtSteps-1:0] v_q;
  logic [SqrtSteps:0]   en;

  always_comb begin
    sq_t seed;
    seed.n   = in_sum_i;
    seed.res = '0;
    st_d[0]  = sqrt_step(seed, 0);
    for (int k = 1; k < SqrtSteps; k++) begin
      st_d[k] = sqrt_step(st_q[k-1], k);
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  assign en[SqrtSteps] = out_ready_i;
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < SqrtSteps; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      st_q[0]   <= st_d[0];
      side_q[0] <= in_side_i;
    end
    for (int k = 1; k < SqrtSteps; k++) begin
      if (en[k]) begin
        st_q[k]   <= st_d[k];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[SqrtSteps-1];
  assign out_root_o  = st_q[SqrtSteps-1].res[RootW-1:0];
  assign out_side_o  = side_q[SqrtSteps-1];

endmodule

// ----- sv/srd_div.sv -----
// Pipelined two-lane restoring divider, one quotient bit per stage, with elastic stall.
module srd_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [srd_pkg::NumW-1:0] in_num_x_i,
  input  logic [srd_pkg::NumW-1:0] in_num_y_i,
  input  logic [srd_pkg::DenW-1:0] in_den_i,
  input  srd_pkg::srd_fin_t        in_fin_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [srd_pkg::QW-1:0]   out_q_x_o,
  output logic [srd_pkg::QW-1:0]   out_q_y_o,
  output srd_pkg::srd_fin_t        out_fin_o
);
  import srd_pkg::*;

  typedef struct packed {
    logic [NumW-1:0] rem_x;
    logic [NumW-1:0] rem_y;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic [DenW-1:0] den;
  } dv_t;

  // Try den << sh against both remainders and set quotient bit sh.
  function automatic dv_t div_step(dv_t s, int sh);
    logic [NumW:0] trial;
    dv_t           o;
    trial = (NumW+1)'(s.den) << sh;
    o     = s;
    if ({1'b0, s.rem_x} >= trial) begin
      o.rem_x = s.rem_x - trial[NumW-1:0];
      o.q_x   = s.q_x | (QW'(1) << sh);
    end
    if ({1'b0, s.rem_y} >= trial) begin
      o.rem_y = s.rem_y - trial[NumW-1:0];
      o.q_y   = s.q_y | (QW'(1) << sh);
    end
    return o;
  endfunction

  dv_t                 st_q [DivSteps];
  dv_t                 st_d [DivSteps];
  srd_fin_t            fin_q [DivSteps];
  logic [DivSteps-1:0] v_q;
  logic [DivSteps:0]   en;

  always_comb begin
    dv_t seed;
    seed.rem_x = in_num_x_i;
    seed.rem_y = in_num_y_i;
    seed.q_x   = '0;
    seed.q_y   = '0;
    seed.den   = in_den_i;
    st_d[0]    = div_step(seed, DivSteps - 1);
    for (int k = 1; k < DivSteps; k++) begin
      st_d[k] = div_step(st_q[k-1], DivSteps - 1 - k);
    end
  end

  assign en[DivSteps] = out_ready_i;
  for (genvar k = 0; k < DivSteps; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < DivSteps; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      st_q[0]  <= st_d[0];
      fin_q[0] <= in_fin_i;
    end
    for (int k = 1; k < DivSteps; k++) begin
      if (en[k]) begin
        st_q[k]  <= st_d[k];
        fin_q[k] <= fin_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[DivSteps-1];
  assign out_q_x_o   = st_q[DivSteps-1].q_x;
  assign out_q_y_o   = st_q[DivSteps-1].q_y;
  assign out_fin_o   = fin_q[DivSteps-1];

endmodule

// ----- sv/stick_radial_deadzone.sv -----
// Top level: scaled radial deadzone for one analog stick, fully pipelined.
//
//   channel   | modport | payload            | requests
//   ----------+---------+--------------------+-----------------------------
//   cfg_i     | sink    | deadzone[15:0]     | register write, always ready
//   sample_i  | sink    | x_in, y_in signed  | one stick sample
//   result_o  | source  | x_out, y_out signed| one result per sample
//
// Throughput is one sample per cycle while result_o does not stall; a taken request
// passes through 38 register stages (two front stages, sixteen square root stages,
// three scaling stages, sixteen divider stages and the output register). Every stage
// carries its own valid bit and advances when it is empty or the stage after it
// advances, so bubbles are squeezed out and a stall at result_o holds every request
// in place. Reset clears the valid bits and the deadzone register only.

`include "stick_radial_deadzone_macros.svh"

module stick_radial_deadzone (
  input logic        clk_i,
  input logic        rst_ni,
  srd_cfg_if.sink    cfg_i,
  srd_in_if.sink     sample_i,
  srd_out_if.source  result_o
);
  import srd_pkg::*;

  // Clamp to a signed axis, truncated quotient magnitude with its sign.
  function automatic logic signed [AxisW-1:0] sat_axis(logic [QW-1:0] q, logic neg);
    logic signed [AxisW-1:0] o;
    if (neg) begin
      o = (q > 16'd32768) ? 16'sh8000 : AxisW'(16'd0 - q);
    end else begin
      o = (q > 16'd32767) ? 16'sh7fff : AxisW'(q);
    end
    return o;
  endfunction

  // Deadzone register: user must write it only while the pipe is idle; not enforced.
  logic [CfgW-1:0] deadzone_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= '0;
    end else if (cfg_i.valid) begin
      deadzone_q <= cfg_i.deadzone;
    end
  end

  // Stage enables, chained back from the output register.
  logic en1, en2, en3, en4, en5, en6;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_valid_q;

  logic sq_in_ready, sq_out_valid;
  logic dv_in_ready, dv_out_valid;

  assign en6 = !out_valid_q || result_o.ready;
  assign en5 = !s5_v_q || dv_in_ready;
  assign en4 = !s4_v_q || en5;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || sq_in_ready;
  assign en1 = !s1_v_q || en2;

  assign sample_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) s1_v_q      <= sample_i.valid;
      if (en2) s2_v_q      <= s1_v_q;
      if (en3) s3_v_q      <= sq_out_valid;
      if (en4) s4_v_q      <= s3_v_q;
      if (en5) s5_v_q      <= s4_v_q;
      if (en6) out_valid_q <= dv_out_valid;
    end
  end

  // Stage 1: squares of both axes, the deadzone edge dq = dz * 32767 and the bypass flag.
  logic [CfgW-1:0]         dz_clamp;
  logic signed [AxisW-1:0] s1_x_q, s1_y_q;
  logic [SumW-1:0]         s1_sqx_q, s1_sqy_q;
  logic [DqW-1:0]          s1_dq_q;
  logic                    s1_bypass_q;

  assign dz_clamp = (deadzone_q > DzMaxReg) ? DzMaxReg : deadzone_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_x_q      <= sample_i.x_in;
      s1_y_q      <= sample_i.y_in;
      s1_sqx_q    <= SumW'(sample_i.x_in) * SumW'(sample_i.x_in);
      s1_sqy_q    <= SumW'(sample_i.y_in) * SumW'(sample_i.y_in);
      s1_dq_q     <= (DqW'(dz_clamp) << FullShift) - DqW'(dz_clamp);
      s1_bypass_q <= (deadzone_q == '0);
    end
  end

  // Stage 2: sum of squares, at most 2^31.
  logic [SumW-1:0] s2_sum_q;
  srd_side_t       s2_side_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_sum_q         <= s1_sqx_q + s1_sqy_q;
      s2_side_q.x      <= s1_x_q;
      s2_side_q.y      <= s1_y_q;
      s2_side_q.dq     <= s1_dq_q;
      s2_side_q.bypass <= s1_bypass_q;
    end
  end

  // Vector length r = floor(sqrt(sum)).
  logic [RootW-1:0] sq_root;
  srd_side_t        sq_side;

  srd_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_v_q),
    .in_ready_o  (sq_in_ready),
    .in_sum_i    (s2_sum_q),
    .in_side_i   (s2_side_q),
    .out_valid_o (sq_out_valid),
    .out_ready_i (en3),
    .out_root_o  (sq_root),
    .out_side_o  (sq_side)
  );

  // Stage 3: deadzone test, numerator core rc*65536 - dq, denominator core
  // 32767*65536 - dq and axis magnitudes. Inside the deadzone the cores are
  // meaningless; the flag overrides them at the output.
  logic [FullShift-1:0] rc;
  logic [DqW-1:0]       s3_num_q, s3_dden_q;
  logic [RootW-1:0]     s3_r_q;
  logic [AxisW-1:0]     s3_mag_x_q, s3_mag_y_q;
  srd_fin_t             s3_fin_q;

  assign rc = (sq_root > RootClamp) ? RootClamp[FullShift-1:0] : sq_root[FullShift-1:0];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_num_q         <= {rc, 16'd0} - sq_side.dq;
      s3_dden_q        <= DzFullOne - sq_side.dq;
      s3_r_q           <= sq_root;
      s3_mag_x_q       <= sq_side.x[AxisW-1] ? AxisW'(-sq_side.x) : AxisW'(sq_side.x);
      s3_mag_y_q       <= sq_side.y[AxisW-1] ? AxisW'(-sq_side.y) : AxisW'(sq_side.y);
      s3_fin_q.x       <= sq_side.x;
      s3_fin_q.y       <= sq_side.y;
      s3_fin_q.bypass  <= sq_side.bypass;
      s3_fin_q.in_zone <= ({sq_root, 16'd0} < {1'b0, sq_side.dq});
    end
  end

  // Stage 4: three parallel multiplies, each at most 31 by 16 bits.
  logic [DenW-1:0]  s4_den_q;
  logic [ProdW-1:0] s4_px_q, s4_py_q;
  srd_fin_t         s4_fin_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_den_q <= DenW'(s3_dden_q) * DenW'(s3_r_q);
      s4_px_q  <= ProdW'(s3_mag_x_q) * ProdW'(s3_num_q);
      s4_py_q  <= ProdW'(s3_mag_y_q) * ProdW'(s3_num_q);
      s4_fin_q <= s3_fin_q;
    end
  end

  // Stage 5: times 32767 as a shift and subtract.
  logic [NumW-1:0] s5_nx_q, s5_ny_q;
  logic [DenW-1:0] s5_den_q;
  srd_fin_t        s5_fin_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_nx_q  <= (NumW'(s4_px_q) << FullShift) - NumW'(s4_px_q);
      s5_ny_q  <= (NumW'(s4_py_q) << FullShift) - NumW'(s4_py_q);
      s5_den_q <= s4_den_q;
      s5_fin_q <= s4_fin_q;
    end
  end

  // Quotient per axis, sixteen bits: the scaled magnitude never tops 32767.
  logic [QW-1:0] dv_q_x, dv_q_y;
  srd_fin_t      dv_fin;

  srd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s5_v_q),
    .in_ready_o  (dv_in_ready),
    .in_num_x_i  (s5_nx_q),
    .in_num_y_i  (s5_ny_q),
    .in_den_i    (s5_den_q),
    .in_fin_i    (s5_fin_q),
    .out_valid_o (dv_out_valid),
    .out_ready_i (en6),
    .out_q_x_o   (dv_q_x),
    .out_q_y_o   (dv_q_y),
    .out_fin_o   (dv_fin)
  );

  // Output register: bypass first, then the deadzone, then the scaled axes.
  logic signed [AxisW-1:0] out_x_d, out_y_d, out_x_q, out_y_q;

  always_comb begin
    priority if (dv_fin.bypass) begin
      out_x_d = dv_fin.x;
      out_y_d = dv_fin.y;
    end else if (dv_fin.in_zone) begin
      out_x_d = '0;
      out_y_d = '0;
    end else begin
      out_x_d = sat_axis(dv_q_x, dv_fin.x[AxisW-1]);
      out_y_d = sat_axis(dv_q_y, dv_fin.y[AxisW-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.x_out = out_x_q;
  assign result_o.y_out = out_y_q;

  // The root of a sum of two 16-bit squares stays within 46340.
  `SRD_ASSERT_IMPL(a_root_bound, sq_out_valid, sq_root <= RootMax, "root out of range")

  // A live scaled sample never needs saturation.
  `SRD_ASSERT_IMPL(a_quot_bound, dv_out_valid && !dv_fin.bypass && !dv_fin.in_zone,
    dv_q_x <= 16'd32767 && dv_q_y <= 16'd32767, "quotient above full deflection")

  // Back-pressure at the input only arises from a full pipe held at the output.
  `SRD_ASSERT_IMPL(a_stall_source, !sample_i.ready,
    result_o.valid && !result_o.ready, "input stalled without output stall")

endmodule

// ----- verif/stick_radial_deadzone_tb.sv -----
// Self-checking testbench for the stick radial deadzone: predicts every result and compares.
`timescale 1ns / 1ps

module stick_radial_deadzone_tb;
  import srd_pkg::*;

  localparam int ClkPeriod  = 10;
  localparam int DrainTail  = 40;       // idle tail after the last result returns
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 50;
  localparam int NumPhases  = 8;

  localparam longint unsigned FullScale = 64'd32767;  // full stick deflection
  localparam longint unsigned UnitQ16   = 64'd65536;  // one in Q0.16

  typedef struct packed {
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
  } axis_pair_t;

  // Stimulus flavours for the random part.
  typedef enum int {
    SpreadFull,  // any 16-bit value on both axes
    SpreadEdge,  // vector length around the deadzone edge
    SpreadRim,   // one axis pinned at full deflection
    SpreadTiny   // close to the centre
  } spread_e;

  // Directed samples: centre, axis extremes, diagonals, tiny and mid vectors.
  localparam logic signed [AxisW-1:0] CornerX [12] = '{
    16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767,
    -16'sd32768, 16'sd32767, 16'sd1, -16'sd1, 16'sd100, 16'sd20000
  };
  localparam logic signed [AxisW-1:0] CornerY [12] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767,
    -16'sd32768, -16'sd32768, 16'sd1, 16'sd0, 16'sd100, -16'sd15000
  };

  // Scoreboard: own copy of the deadzone register and the queue of predicted samples.
  class deadzone_scoreboard;
    logic [CfgW-1:0] deadzone;
    axis_pair_t      expected_q[$];
    int              errors;

    function new();
      deadzone = '0;
      errors   = 0;
    endfunction

    function void write_deadzone(logic [CfgW-1:0] value);
      deadzone = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function longint unsigned floor_root(longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= n) root = trial;
      end
      return root;
    endfunction

    function logic signed [AxisW-1:0] stretch_axis(logic signed [AxisW-1:0] v,
                                                    longint unsigned core,
                                                    longint unsigned den);
      int              vi;
      int              res;
      longint unsigned mag;
      longint unsigned q;
      vi  = v;
      mag = (vi < 0) ? longint'(-vi) : longint'(vi);
      q   = (mag * core * FullScale) / den;
      if (vi < 0) res = (q > 64'd32768) ? -32768 : -int'(q);
      else        res = (q > 64'd32767) ? 32767 : int'(q);
      return res[AxisW-1:0];
    endfunction

    function axis_pair_t rescale_sample(logic signed [AxisW-1:0] x,
                                        logic signed [AxisW-1:0] y);
      axis_pair_t      p;
      logic [CfgW-1:0] dz;
      longint unsigned dz_edge;
      longint unsigned sum;
      longint unsigned r;
      longint unsigned rc;
      longint unsigned core;
      longint unsigned den;
      longint          xi;
      longint          yi;
      dz = (deadzone > DzMaxReg) ? DzMaxReg : deadzone;
      p.x = x;
      p.y = y;
      if (dz == '0) return p;
      xi      = x;
      yi      = y;
      dz_edge = longint'(dz) * FullScale;
      sum     = longint'(xi * xi + yi * yi);
      r       = floor_root(sum);
      if (r * UnitQ16 < dz_edge) return '0;
      rc   = (r > FullScale) ? FullScale : r;
      core = rc * UnitQ16 - dz_edge;
      den  = (longint'(DzFullOne) - dz_edge) * r;
      p.x  = stretch_axis(x, core, den);
      p.y  = stretch_axis(y, core, den);
      return p;
    endfunction

    function void note_sample(logic signed [AxisW-1:0] x, logic signed [AxisW-1:0] y);
      expected_q.push_back(rescale_sample(x, y));
    endfunction

    function void check_result(logic signed [AxisW-1:0] x, logic signed [AxisW-1:0] y);
      axis_pair_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d, nothing outstanding", $time, x, y);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (want.x !== x) begin
        $display("%0t: x_out mismatch, expected %0d, actual %0d", $time, want.x, x);
        errors++;
      end
      if (want.y !== y) begin
        $display("%0t: y_out mismatch, expected %0d, actual %0d", $time, want.y, y);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   stall_pct;
  int   cycles;

  deadzone_scoreboard sb;

  srd_cfg_if cfg ();
  srd_in_if  smp ();
  srd_out_if res ();

  stick_radial_deadzone dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (smp),
    .result_o (res)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Receiver: drop ready at random according to the stall rate of the phase.
  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: every request is sampled on the edge where it is taken, before any
  // testbench or block update of that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) sb.write_deadzone(cfg.deadzone);
      if (smp.valid && smp.ready) sb.note_sample(smp.x_in, smp.y_in);
      if (res.valid && res.ready) sb.check_result(res.x_out, res.y_out);
    end
  end

  // Watchdog: abandon a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: run exceeded %0d cycles", $time, CycleLimit);
      $display("FAIL stick_radial_deadzone");
      $finish;
    end
  end

  function automatic logic signed [AxisW-1:0] clamp_axis(int v);
    int c;
    c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    return c[AxisW-1:0];
  endfunction

  // Draw one sample, biased towards the interesting regions for this deadzone.
  function automatic axis_pair_t random_stick(logic [CfgW-1:0] dz);
    axis_pair_t p;
    int         eff;
    int         span;
    spread_e    kind;
    eff  = (dz > DzMaxReg) ? int'(DzMaxReg) : int'(dz);
    // Deadzone radius in axis steps plus an eighth either side.
    span = ((eff * 32767) >>> 16) + ((eff * 32767) >>> 19) + 8;
    kind = spread_e'($urandom_range(0, 3));
    case (kind)
      SpreadFull: begin
        p.x = clamp_axis(int'($urandom_range(0, 65535)) - 32768);
        p.y = clamp_axis(int'($urandom_range(0, 65535)) - 32768);
      end
      SpreadEdge: begin
        p.x = clamp_axis(int'($urandom_range(0, 2 * span)) - span);
        p.y = clamp_axis(int'($urandom_range(0, 2 * span)) - span);
      end
      SpreadRim: begin
        p.x = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
        p.y = clamp_axis(int'($urandom_range(0, 65535)) - 32768);
        if ($urandom_range(0, 1)) p = '{x: p.y, y: p.x};
      end
      default: begin
        p.x = clamp_axis(int'($urandom_range(0, 600)) - 300);
        p.y = clamp_axis(int'($urandom_range(0, 600)) - 300);
      end
    endcase
    return p;
  endfunction

  // Write the deadzone register; only called with the pipeline empty.
  task automatic write_deadzone(input logic [CfgW-1:0] value);
    cfg.valid    <= 1'b1;
    cfg.deadzone <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // Offer one sample, idling first at the sender's rate; valid stays high afterwards
  // so back-to-back requests are not broken up.
  task automatic send_sample(input logic signed [AxisW-1:0] x,
                             input logic signed [AxisW-1:0] y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid <= 1'b1;
    smp.x_in  <= x;
    smp.y_in  <= y;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
  endtask

  // Hold the sender off until every predicted result has come back, then let the
  // pipeline settle.
  task automatic drain_results();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 46; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 46; end
      default: begin send_idle_pct = 32; stall_pct = 32; end
    endcase
  endtask

  initial begin
    logic [CfgW-1:0] phase_dz [NumPhases];
    axis_pair_t      p;

    sb            = new();
    send_idle_pct = 0;
    stall_pct     = 0;

    // Drive every sender input to a known value from time zero.
    rst_ni       <= 1'b0;
    cfg.valid    <= 1'b0;
    cfg.deadzone <= '0;
    smp.valid    <= 1'b0;
    smp.x_in     <= '0;
    smp.y_in     <= '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part: the corner samples in bypass, then at the largest deadzone.
    set_idling(0);
    write_deadzone('0);
    foreach (CornerX[i]) send_sample(CornerX[i], CornerY[i]);
    drain_results();
    write_deadzone(DzMaxReg);
    foreach (CornerX[i]) send_sample(CornerX[i], CornerY[i]);
    drain_results();

    // Random part: smallest nonzero, above the limit, mid values, just under the
    // limit, bypass again and two random settings; idling rotates per phase.
    phase_dz = '{16'd1, 16'hFFFF, 16'd16384, 16'($urandom_range(0, 65535)),
                 DzMaxReg - 16'd1, 16'd0, 16'd3277, 16'($urandom_range(1, 62259))};
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_idling(ph);
      write_deadzone(phase_dz[ph]);
      for (int n = 0; n < PhaseItems; n++) begin
        p = random_stick(phase_dz[ph]);
        send_sample(p.x, p.y);
      end
      drain_results();
    end

    if (sb.errors == 0) begin
      $display("PASS stick_radial_deadzone");
    end else begin
      $display("FAIL stick_radial_deadzone");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/srd_pkg.sv
sv/srd_if.sv
sv/srd_isqrt.sv
sv/srd_div.sv
sv/stick_radial_deadzone.sv
verif/stick_radial_deadzone_tb.sv
